/* hw/rtl/sfth_pkg.sv */
// Package for the symmetric flow tuple hash: field widths, mix constants, types, mix function.
`default_nettype none
package sfth_pkg;

   localparam int unsigned ADDR_WORD_W = 32;
   localparam int unsigned PORT_W      = 16;
   localparam int unsigned HASH_W      = 32;
   localparam int unsigned ADDR_WORDS  = 4;
   localparam int unsigned REQ_DATA_W  = 2 * ADDR_WORDS * ADDR_WORD_W + 2 * PORT_W;
   localparam int unsigned RSP_DATA_W  = HASH_W;

   localparam logic [HASH_W-1:0] GOLDEN_K = 32'h9e37_79b9;
   localparam int unsigned       MIX_SHL  = 6;
   localparam int unsigned       MIX_SHR  = 2;

   typedef logic [ADDR_WORD_W-1:0] word_type;
   typedef logic [PORT_W-1:0]      port_type;
   typedef logic [HASH_W-1:0]      hash_type;

   // one flow tuple as captured at the input register
   typedef struct packed {
      port_type                  dst_port;
      port_type                  src_port;
      word_type [ADDR_WORDS-1:0] dst_addr;
      word_type [ADDR_WORDS-1:0] src_addr;
   } tuple_type;

   typedef struct packed {
      logic     direction;
      hash_type flow_hash;
   } result_type;

   // golden-ratio combine, all sums mod 2^32
   function automatic hash_type mix_word(hash_type seed, hash_type v);
      hash_type sum;
      sum = v + GOLDEN_K + (seed << MIX_SHL) + (seed >> MIX_SHR);
      return seed ^ sum;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/symmetric_flow_tuple_hash.sv */
// Top level of the symmetric flow tuple hash: input register, mix logic, result register.
// A req transfer is captured in the input register and then in the result register, which
// drives rsp_tvalid; the rsp transfer follows when rsp_tready is high.
// Throughput: one tuple per cycle unless rsp_tready stalls the result; the order compare
// and the eight-word mix chain are combinational, between the input and result registers.
// A stalled result stalls a full input register behind it; both stages then hold.
// Reset (synchronous, active high) clears both valid flags; payload registers keep no reset.
`default_nettype none
module symmetric_flow_tuple_hash (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // lowest bit up: src_addr_w0, src_addr_w1, src_addr_w2, src_addr_w3,
   // dst_addr_w0, dst_addr_w1, dst_addr_w2, dst_addr_w3, src_port, dst_port
   input  wire  [sfth_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // lowest bit up: flow_hash
   output logic [sfth_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // lowest bit up: direction
   output logic                                rsp_tuser
);

   logic                  tuple_valid_ff;
   sfth_pkg::tuple_type   tuple_ff;
   sfth_pkg::tuple_type   tuple_in;
   logic                  rsp_valid_ff;
   sfth_pkg::result_type  result_ff;
   sfth_pkg::result_type  result_in;
   logic                  out_en;
   logic                  tuple_en;

   logic [2*sfth_pkg::ADDR_WORD_W-1:0] src_lo, src_hi, dst_lo, dst_hi;
   logic                               src_first;
   sfth_pkg::word_type [2*sfth_pkg::ADDR_WORDS-1:0] fold_words;
   sfth_pkg::hash_type                 addr_seed;
   sfth_pkg::hash_type                 port_seed;
   sfth_pkg::port_type                 first_port, second_port;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign tuple_en   = !tuple_valid_ff || out_en;
   assign req_tready = tuple_en;
   assign tuple_in   = sfth_pkg::tuple_type'(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         tuple_valid_ff <= 1'b0;
      end else if (tuple_en) begin
         tuple_valid_ff <= req_tvalid;
      end
      if (tuple_en && req_tvalid) begin
         tuple_ff <= tuple_in;
      end
   end

   // canonical order: ports, then low halves, then high halves; a full tie is destination-first
   always_comb begin
      src_lo = {tuple_ff.src_addr[1], tuple_ff.src_addr[0]};
      src_hi = {tuple_ff.src_addr[3], tuple_ff.src_addr[2]};
      dst_lo = {tuple_ff.dst_addr[1], tuple_ff.dst_addr[0]};
      dst_hi = {tuple_ff.dst_addr[3], tuple_ff.dst_addr[2]};
      if (tuple_ff.src_port != tuple_ff.dst_port) begin
         src_first = tuple_ff.src_port > tuple_ff.dst_port;
      end else if (src_lo != dst_lo) begin
         src_first = src_lo > dst_lo;
      end else begin
         src_first = src_hi > dst_hi;
      end
   end

   always_comb begin
      if (src_first) begin
         fold_words  = {tuple_ff.dst_addr, tuple_ff.src_addr};
         first_port  = tuple_ff.src_port;
         second_port = tuple_ff.dst_port;
      end else begin
         fold_words  = {tuple_ff.src_addr, tuple_ff.dst_addr};
         first_port  = tuple_ff.dst_port;
         second_port = tuple_ff.src_port;
      end
      addr_seed = '0;
      for (int i = 0; i < 2 * sfth_pkg::ADDR_WORDS; i++) begin
         addr_seed = sfth_pkg::mix_word(addr_seed, fold_words[i]);
      end
      port_seed = sfth_pkg::mix_word('0, sfth_pkg::hash_type'(first_port));
      port_seed = sfth_pkg::mix_word(port_seed, sfth_pkg::hash_type'(second_port));
      result_in.flow_hash = addr_seed ^ port_seed;
      result_in.direction = !src_first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= tuple_valid_ff;
      end
      if (out_en && tuple_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff.flow_hash;
   assign rsp_tuser  = result_ff.direction;

`ifndef SYNTHESIS
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_tuple_moves: assert property (@(posedge clock) disable iff (reset)
      (tuple_valid_ff && out_en) |=> rsp_tvalid)
      else $error("captured tuple did not reach result register");

   a_src_port_wins: assert property (@(posedge clock) disable iff (reset)
      (tuple_valid_ff && out_en && (tuple_ff.src_port > tuple_ff.dst_port)) |=> !rsp_tuser)
      else $error("larger source port must give source-first order");

   a_dst_port_wins: assert property (@(posedge clock) disable iff (reset)
      (tuple_valid_ff && out_en && (tuple_ff.src_port < tuple_ff.dst_port)) |=> rsp_tuser)
      else $error("larger destination port must give destination-first order");
`endif

endmodule
`default_nettype wire
